// ===== sv/pmc_pkg.sv =====
`timescale 1ns / 1ps

package pmc_pkg;

    typedef enum logic [1:0] {
        RUN_DEFAULT,
        RUN_DEBUG,
        RUN_MANUAL,
        RUN_AUTO
    } run_mode_t;

    typedef enum logic [1:0] {
        AUTO_NONE,
        AUTO_FULL,
        AUTO_GIMBAL,
        AUTO_CHASSIS
    } auto_mode_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SET_START,
        PH_SET_END,
        PH_MEAS_START,
        PH_MEASURING,
        PH_MEAS_END
    } phase_t;

    // remote switch positions
    localparam logic [1:0] SW_INVALID = 2'd0;
    localparam logic [1:0] SW_TOP     = 2'd1;
    localparam logic [1:0] SW_MIDDLE  = 2'd2;
    localparam logic [1:0] SW_BOTTOM  = 2'd3;

    // configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PATROL_SPEED  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FEED_SPEED    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_JAM_TICKS     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRIC_ON       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRIC_OFF      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_STORED_LENGTH = 3'd5;

    localparam int CFG_DATA_W = 32;

    localparam logic [13:0] PATROL_SPEED_RST  = 14'd1200;
    localparam logic [13:0] FEED_SPEED_RST    = 14'd2000;
    localparam logic [9:0]  JAM_TICKS_RST     = 10'd100;
    localparam logic [15:0] FRIC_ON_RST       = 16'd1900;
    localparam logic [15:0] FRIC_OFF_RST      = 16'd800;
    localparam logic [31:0] STORED_LENGTH_RST = 32'd0;

    // input word, last field in the lowest bits
    typedef struct packed {
        logic               feeder_saturated;
        logic signed [10:0] stick_x;
        logic signed [15:0] wheel_rate;
        logic [1:0]         left_switch;
        logic [1:0]         right_switch;
    } item_t;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic [1:0]         pad;
        phase_t             track_phase;
        logic signed [31:0] saved_length;
        logic               save_strobe;
        logic [15:0]        friction_compare;
        logic signed [14:0] feeder_speed;
        logic signed [14:0] chassis_speed;
        auto_mode_t         auto_mode;
        run_mode_t          run_mode;
    } result_t;

    // drive settings
    typedef struct packed {
        logic [13:0] patrol_speed;
        logic [13:0] feed_speed;
        logic [9:0]  jam_ticks;
        logic [15:0] fric_on;
        logic [15:0] fric_off;
    } drive_cfg_t;

    // mode state after the current tick
    typedef struct packed {
        run_mode_t          run_mode;
        auto_mode_t         auto_mode;
        phase_t             phase;
        logic signed [31:0] length;
        logic signed [31:0] position;
        logic               fire_enable;
        logic               save_strobe;
    } mode_state_t;

    typedef struct packed {
        logic signed [14:0] chassis_speed;
        logic signed [14:0] feeder_speed;
        logic [15:0]        friction_compare;
    } drive_out_t;

    function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                     input logic signed [15:0] b);
        logic signed [32:0] sum;
        begin
            sum = 33'(a) + 33'(b);
            if (sum[32] != sum[31]) begin
                sat_add32 = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                sat_add32 = sum[31:0];
            end
        end
    endfunction

endpackage

// ===== sv/pmc_mode_ctrl.sv =====
`timescale 1ns / 1ps

module pmc_mode_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  pmc_pkg::item_t       item,
    input  logic                 len_load,
    input  logic signed [31:0]   len_value,
    output pmc_pkg::mode_state_t tick
);
    import pmc_pkg::*;

    run_mode_t          mode_reg, mode_next;
    auto_mode_t         auto_reg, auto_next;
    phase_t             phase_reg, phase_next;
    logic signed [31:0] length_reg, length_next;
    logic signed [31:0] position_reg, position_next, pos_base;
    logic               fire_reg, fire_next;
    logic               strobe;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= RUN_DEFAULT;
            auto_reg     <= AUTO_NONE;
            phase_reg    <= PH_IDLE;
            length_reg   <= STORED_LENGTH_RST;
            position_reg <= '0;
            fire_reg     <= 1'b0;
        end else begin
            if (advance) begin
                mode_reg     <= mode_next;
                auto_reg     <= auto_next;
                phase_reg    <= phase_next;
                length_reg   <= length_next;
                position_reg <= position_next;
                fire_reg     <= fire_next;
            end
            if (len_load) begin
                length_reg <= len_value;
            end
        end
    end

    always_comb begin
        mode_next   = mode_reg;
        auto_next   = auto_reg;
        phase_next  = phase_reg;
        length_next = length_reg;
        fire_next   = fire_reg;
        pos_base    = position_reg;
        strobe      = 1'b0;
        case (item.right_switch)
            SW_TOP: begin
                mode_next = RUN_DEBUG;
                if (item.left_switch == SW_MIDDLE &&
                    (phase_reg == PH_SET_START || phase_reg == PH_SET_END)) begin
                    phase_next  = PH_MEAS_START;
                    length_next = '0;
                end else if ((item.left_switch == SW_TOP || item.left_switch == SW_BOTTOM) &&
                             phase_reg == PH_MEASURING) begin
                    phase_next = PH_MEAS_END;
                    strobe     = 1'b1;
                end else if (item.left_switch == SW_MIDDLE) begin
                    phase_next  = PH_MEASURING;
                    length_next = sat_add32(length_reg, item.wheel_rate);
                end else if (item.left_switch == SW_BOTTOM) begin
                    phase_next = PH_SET_START;
                    pos_base   = '0;
                end else if (item.left_switch == SW_TOP) begin
                    phase_next = PH_SET_END;
                    pos_base   = length_reg;
                end else begin
                    mode_next = RUN_DEFAULT;
                end
            end
            SW_MIDDLE: begin
                mode_next = RUN_MANUAL;
                fire_next = (item.left_switch == SW_TOP);
            end
            SW_BOTTOM: begin
                mode_next = RUN_AUTO;
                case (item.left_switch)
                    SW_MIDDLE: auto_next = AUTO_FULL;
                    SW_TOP:    auto_next = AUTO_GIMBAL;
                    SW_BOTTOM: auto_next = AUTO_CHASSIS;
                    default:   auto_next = auto_reg;
                endcase
            end
            default: begin
                mode_next = RUN_DEFAULT;
            end
        endcase
        position_next = sat_add32(pos_base, item.wheel_rate);
    end

    assign tick.run_mode    = mode_next;
    assign tick.auto_mode   = auto_next;
    assign tick.phase       = phase_next;
    assign tick.length      = length_next;
    assign tick.position    = position_next;
    assign tick.fire_enable = fire_next;
    assign tick.save_strobe = strobe;

`ifndef SYNTHESIS
    // measuring starts only from a set start or set end phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && phase_next == PH_MEAS_START && phase_reg != PH_MEAS_START
        |-> phase_reg == PH_SET_START || phase_reg == PH_SET_END)
        else $error("measure start entered from wrong phase");

    assert property (@(posedge aclk) disable iff (!aresetn)
        strobe |-> phase_reg == PH_MEASURING && mode_next == RUN_DEBUG)
        else $error("save strobe outside end of measuring");

    // fire enable moves only on a manual tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && fire_next != fire_reg |-> item.right_switch == SW_MIDDLE)
        else $error("fire enable changed outside manual mode");
`endif

endmodule

// ===== sv/pmc_drive_ctrl.sv =====
`timescale 1ns / 1ps

module pmc_drive_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  pmc_pkg::drive_cfg_t  cfg,
    input  pmc_pkg::mode_state_t tick,
    input  logic signed [10:0]   stick_x,
    input  logic                 feeder_saturated,
    output pmc_pkg::drive_out_t  drive
);
    import pmc_pkg::*;

    logic               forward_reg, forward_next;
    logic signed [10:0] jam_timer_reg, jam_timer_next;
    logic [31:0]        pos_mag, len_mag;
    logic [36:0]        pos_x20, len_x19;
    logic signed [14:0] patrol15, feed15;
    logic signed [11:0] jam_limit;
    logic               reverse;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            forward_reg   <= 1'b1;
            jam_timer_reg <= '0;
        end else if (advance) begin
            forward_reg   <= forward_next;
            jam_timer_reg <= jam_timer_next;
        end
    end

    // reversal zones: near the start (5%) and near the end (95%) of the track
    assign pos_mag = tick.position[31] ? 32'(-tick.position) : 32'(tick.position);
    assign len_mag = tick.length[31] ? 32'(-tick.length) : 32'(tick.length);
    assign pos_x20 = 37'({pos_mag, 4'b0000}) + 37'({pos_mag, 2'b00});
    assign len_x19 = 37'({len_mag, 4'b0000}) + 37'({len_mag, 1'b0}) + 37'(len_mag);

    assign patrol15  = signed'({1'b0, cfg.patrol_speed});
    assign feed15    = signed'({1'b0, cfg.feed_speed});
    assign jam_limit = signed'({2'b00, cfg.jam_ticks});

    always_comb begin
        forward_next = forward_reg;
        if (tick.run_mode == RUN_AUTO) begin
            if (pos_x20 < 37'(len_mag)) begin
                forward_next = 1'b1;
            end else if (pos_x20 > len_x19) begin
                forward_next = 1'b0;
            end
        end

        case (tick.run_mode)
            RUN_DEBUG, RUN_MANUAL: begin
                drive.chassis_speed = {{3{stick_x[10]}}, stick_x, 1'b0};
            end
            RUN_AUTO: begin
                if (tick.length == '0) begin
                    drive.chassis_speed = '0;
                end else if (forward_next ^ tick.length[31]) begin
                    drive.chassis_speed = patrol15;
                end else begin
                    drive.chassis_speed = -patrol15;
                end
            end
            default: begin
                drive.chassis_speed = '0;
            end
        endcase

        // anti-jam: count saturated ticks, then run reverse for as many
        reverse = 1'b0;
        if (12'(jam_timer_reg) >= jam_limit) begin
            jam_timer_next = 11'(-jam_limit);
        end else if (jam_timer_reg < 0) begin
            reverse        = 1'b1;
            jam_timer_next = jam_timer_reg + 11'sd1;
        end else if (tick.fire_enable && feeder_saturated) begin
            jam_timer_next = jam_timer_reg + 11'sd1;
        end else begin
            jam_timer_next = '0;
        end

        if (!tick.fire_enable) begin
            drive.feeder_speed = '0;
        end else if (reverse) begin
            drive.feeder_speed = feed15;
        end else begin
            drive.feeder_speed = -feed15;
        end

        drive.friction_compare = tick.fire_enable ? cfg.fric_on : cfg.fric_off;
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        drive.feeder_speed != '0 |-> tick.fire_enable)
        else $error("feeder runs with firing disabled");

    // direction flips only on an auto tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && forward_next != forward_reg |-> tick.run_mode == RUN_AUTO)
        else $error("patrol direction changed outside auto mode");

    // a reversal counts up by one per tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && jam_timer_reg < 0 |=> jam_timer_reg == $past(jam_timer_reg) + 11'sd1)
        else $error("reversal timer did not count up");
`endif

endmodule

// ===== sv/patrol_mode_controller.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Word bits  Fields (lowest bit up)
// s_axis    in         32         right_switch, left_switch, wheel_rate, stick_x,
//                                 feeder_saturated
// m_axis    out        88         run_mode, auto_mode, chassis_speed, feeder_speed,
//                                 friction_compare, save_strobe, saved_length, track_phase
// cfg       in         32         write-only registers 0..5
//
// One word per clock sustained while m_tready stays high; the result register loads when the
// input register holds a word and the result register is empty or being read (input
// register, then result register, with the tick logic in between).
// Reset is synchronous and clears all mode, phase, accumulator and timer state.
// A stalled result holds in the result register while the input register takes one
// more word; s_tready drops only when both are full and m_tready is low.

module patrol_mode_controller (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // right_switch[1:0], left_switch[3:2], wheel_rate[19:4], stick_x[30:20],
    // feeder_saturated[31]
    input  logic [31:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // run_mode[1:0], auto_mode[3:2], chassis_speed[18:4], feeder_speed[33:19],
    // friction_compare[49:34], save_strobe[50], saved_length[82:51], track_phase[85:83]
    output logic [87:0] m_tdata,

    input  logic                            cfg_we,
    input  logic [pmc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [pmc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import pmc_pkg::*;

    drive_cfg_t  cfg_reg;
    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        out_valid_reg;
    result_t     out_data_reg;
    logic        advance;
    logic        len_load;
    mode_state_t tick;
    drive_out_t  drive;
    result_t     result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.patrol_speed <= PATROL_SPEED_RST;
            cfg_reg.feed_speed   <= FEED_SPEED_RST;
            cfg_reg.jam_ticks    <= JAM_TICKS_RST;
            cfg_reg.fric_on      <= FRIC_ON_RST;
            cfg_reg.fric_off     <= FRIC_OFF_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_PATROL_SPEED: cfg_reg.patrol_speed <= cfg_wdata[13:0];
                CFG_FEED_SPEED:   cfg_reg.feed_speed   <= cfg_wdata[13:0];
                CFG_JAM_TICKS:    cfg_reg.jam_ticks    <= cfg_wdata[9:0];
                CFG_FRIC_ON:      cfg_reg.fric_on      <= cfg_wdata[15:0];
                CFG_FRIC_OFF:     cfg_reg.fric_off     <= cfg_wdata[15:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // stored length goes straight into the length accumulator
    assign len_load = cfg_we && (cfg_addr == CFG_STORED_LENGTH);

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= item_t'(s_tdata);
        end
    end

    pmc_mode_ctrl u_mode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (in_item_reg),
        .len_load  (len_load),
        .len_value (signed'(cfg_wdata)),
        .tick      (tick)
    );

    pmc_drive_ctrl u_drive (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .advance          (advance),
        .cfg              (cfg_reg),
        .tick             (tick),
        .stick_x          (in_item_reg.stick_x),
        .feeder_saturated (in_item_reg.feeder_saturated),
        .drive            (drive)
    );

    always_comb begin
        result.pad              = '0;
        result.track_phase      = tick.phase;
        result.saved_length     = tick.save_strobe ? tick.length : '0;
        result.save_strobe      = tick.save_strobe;
        result.friction_compare = drive.friction_compare;
        result.feeder_speed     = drive.feeder_speed;
        result.chassis_speed    = drive.chassis_speed;
        result.auto_mode        = tick.auto_mode;
        result.run_mode         = tick.run_mode;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_data_reg.save_strobe |-> out_data_reg.track_phase == PH_MEAS_END)
        else $error("save strobe without end of measuring");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !out_data_reg.save_strobe |-> out_data_reg.saved_length == '0)
        else $error("saved length set without strobe");

    // input stalls only when both registers are full and the output is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with room available");

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("tick result lost");
`endif

endmodule
